/* hw/rtl/skt_pkg.sv */
// Shared types and constants for the sorted key table.
package skt_pkg;

	localparam int KEY_W     = 32;
	localparam int ACT_W     = 2;
	localparam int STS_W     = 2;
	localparam int POS_OUT_W = 3;
	localparam int CNT_OUT_W = 4;

	// Request actions
	typedef enum logic [ACT_W-1:0] {
		ACT_INSERT = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_SEARCH = 2'd2,
		ACT_CLEAR  = 2'd3
	} action_t;

	// Response status codes
	typedef enum logic [STS_W-1:0] {
		STS_OK      = 2'd0,
		STS_FULL    = 2'd1,
		STS_DUP     = 2'd2,
		STS_MISSING = 2'd3
	} status_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE    = 2'd0,
		ST_COMPARE = 2'd1,
		ST_UPDATE  = 2'd2
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;   // latch the incoming request
		logic evaluate;  // register per-cell compare flags
		logic commit;    // apply the update and load the response
	} cmd_t;

endpackage

/* hw/rtl/skt_dp.sv */
// Datapath: key cells, parallel compare, shift update and response register.
module skt_dp #(
	parameter int CAPACITY = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  skt_pkg::cmd_t                 cmd,
	input  logic [skt_pkg::ACT_W-1:0]     action,
	input  logic signed [skt_pkg::KEY_W-1:0] key,
	output logic [skt_pkg::STS_W-1:0]     status,
	output logic [skt_pkg::POS_OUT_W-1:0] position,
	output logic [skt_pkg::CNT_OUT_W-1:0] count
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	// request registers
	skt_pkg::action_t                act_q;
	logic signed [skt_pkg::KEY_W-1:0] key_q;

	// table state
	logic signed [skt_pkg::KEY_W-1:0] store_q [CAPACITY];
	logic signed [skt_pkg::KEY_W-1:0] store_d [CAPACITY];
	logic [CNT_W-1:0]                 count_q;

	// compare flags
	logic [CAPACITY-1:0] lt_d, eq_d, lt_q, eq_q;
	logic                full_q;

	// decoded update
	logic [CAPACITY-1:0] bound;
	logic                ins_en, del_en;
	logic [IDX_W-1:0]    ins_pos, hit_pos;
	logic                hit;

	// response registers
	logic [skt_pkg::STS_W-1:0] sts_q;
	logic [IDX_W-1:0]          pos_q;
	logic [IDX_W+skt_pkg::POS_OUT_W-1:0] pos_ext;
	logic [CNT_W+skt_pkg::CNT_OUT_W-1:0] cnt_ext;
	skt_pkg::status_t          sts_d;
	logic [IDX_W-1:0]          pos_d;
	logic [CNT_W-1:0]          count_d;

	// latch request
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q <= skt_pkg::action_t'(action);
			key_q <= key;
		end
	end

	// per-cell compare and next value
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic valid;
		assign valid   = CNT_W'(i) < count_q;
		assign lt_d[i] = valid && (store_q[i] < key_q);
		assign eq_d[i] = valid && (store_q[i] == key_q);

		// first cell that is not smaller receives the new key
		if (i == 0) begin : g_b0
			assign bound[i] = !lt_q[i];
		end else begin : g_bn
			assign bound[i] = !lt_q[i] && lt_q[i-1];
		end

		always_comb begin
			store_d[i] = store_q[i];
			if (ins_en && !lt_q[i]) begin
				if (bound[i]) begin
					store_d[i] = key_q;
				end else begin
					store_d[i] = store_q[(i > 0) ? i - 1 : 0];
				end
			end else if (del_en && !lt_q[i] && (i < CAPACITY - 1)) begin
				store_d[i] = store_q[(i < CAPACITY - 1) ? i + 1 : i];
			end
		end

		always_ff @(posedge clk) begin
			if (cmd.commit) begin
				store_q[i] <= store_d[i];
			end
		end
	end

	// register compare flags
	always_ff @(posedge clk) begin
		if (cmd.evaluate) begin
			lt_q   <= lt_d;
			eq_q   <= eq_d;
			full_q <= (count_q == CNT_W'(CAPACITY));
		end
	end

	// encode one-hot flags to indices
	always_comb begin
		ins_pos = '0;
		hit_pos = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			ins_pos = ins_pos | (bound[i] ? IDX_W'(i) : '0);
			hit_pos = hit_pos | (eq_q[i] ? IDX_W'(i) : '0);
		end
	end

	assign hit = |eq_q;

	// decide status, position and count
	always_comb begin
		ins_en  = 1'b0;
		del_en  = 1'b0;
		sts_d   = skt_pkg::STS_OK;
		pos_d   = '0;
		count_d = count_q;
		case (act_q)
			skt_pkg::ACT_INSERT: begin
				if (full_q) begin
					sts_d = skt_pkg::STS_FULL;
				end else if (hit) begin
					sts_d = skt_pkg::STS_DUP;
				end else begin
					ins_en  = 1'b1;
					pos_d   = ins_pos;
					count_d = count_q + CNT_W'(1);
				end
			end
			skt_pkg::ACT_DELETE: begin
				if (hit) begin
					del_en  = 1'b1;
					pos_d   = hit_pos;
					count_d = count_q - CNT_W'(1);
				end else begin
					sts_d = skt_pkg::STS_MISSING;
				end
			end
			skt_pkg::ACT_SEARCH: begin
				if (hit) begin
					pos_d = hit_pos;
				end else begin
					sts_d = skt_pkg::STS_MISSING;
				end
			end
			skt_pkg::ACT_CLEAR: begin
				count_d = '0;
			end
			default: begin
				sts_d = skt_pkg::STS_OK;
			end
		endcase
	end

	// count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= count_d;
		end
	end

	// response register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			sts_q <= sts_d;
			pos_q <= pos_d;
		end
	end

	// fields are masked to their port widths
	assign pos_ext  = {{skt_pkg::POS_OUT_W{1'b0}}, pos_q};
	assign position = pos_ext[skt_pkg::POS_OUT_W-1:0];
	assign cnt_ext  = {{skt_pkg::CNT_OUT_W{1'b0}}, count_q};
	assign count    = cnt_ext[skt_pkg::CNT_OUT_W-1:0];
	assign status   = sts_q;

endmodule

/* hw/rtl/skt_ctrl.sv */
// Controller: sequences compare and update, owns the handshakes.
module skt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output skt_pkg::cmd_t cmd
);

	skt_pkg::state_t state_q, state_d;
	logic            rsp_valid_q;
	logic            commit, accept;

	// update may proceed once the response slot is free
	assign commit = (state_q == skt_pkg::ST_UPDATE) && (!rsp_valid_q || rsp_ready);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			skt_pkg::ST_IDLE: begin
				if (req_valid) state_d = skt_pkg::ST_COMPARE;
			end
			skt_pkg::ST_COMPARE: begin
				state_d = skt_pkg::ST_UPDATE;
			end
			skt_pkg::ST_UPDATE: begin
				if (commit) begin
					state_d = req_valid ? skt_pkg::ST_COMPARE : skt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = skt_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		req_ready    = 1'b0;
		cmd.evaluate = 1'b0;
		cmd.commit   = 1'b0;
		case (state_q)
			skt_pkg::ST_IDLE: begin
				req_ready = 1'b1;
			end
			skt_pkg::ST_COMPARE: begin
				cmd.evaluate = 1'b1;
			end
			skt_pkg::ST_UPDATE: begin
				req_ready  = commit;
				cmd.commit = commit;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
		accept      = req_valid && req_ready;
		cmd.capture = accept;
	end

	// state and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= skt_pkg::ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

`ifndef SYNTHESIS
	a_no_accept_in_compare: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == skt_pkg::ST_COMPARE) |-> !req_ready)
		else $error("request taken during compare");
	a_commit_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> rsp_valid)
		else $error("update without response");
	a_accept_to_compare: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == skt_pkg::ST_COMPARE))
		else $error("accepted request not compared");
	a_stall_holds_update: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == skt_pkg::ST_UPDATE) && rsp_valid && !rsp_ready)
		|=> ((state_q == skt_pkg::ST_UPDATE) && $stable(rsp_valid)))
		else $error("update overran a pending response");
`endif

endmodule

/* hw/rtl/sorted_key_table_unit.sv */
// Flow: an accepted request passes a compare state over all cells in parallel,
// then an update state that shifts the cells and registers the response; a new
// request can be accepted as the update commits. Back-pressure on the response
// side holds the update state.
// Reset: arst_n clears the controller and the key count; key cells are not
// cleared and hold no meaning above the count.
module sorted_key_table_unit #(
	parameter int CAPACITY = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  logic [skt_pkg::ACT_W-1:0]         action,
	input  logic signed [skt_pkg::KEY_W-1:0]  key,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output logic [skt_pkg::STS_W-1:0]         status,
	output logic [skt_pkg::POS_OUT_W-1:0]     position,
	output logic [skt_pkg::CNT_OUT_W-1:0]     count
);

	skt_pkg::cmd_t cmd;

	// sequencing and handshakes
	skt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd)
	);

	// key table and response
	skt_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.action   (action),
		.key      (key),
		.status   (status),
		.position (position),
		.count    (count)
	);

endmodule

/* dv/tb_sorted_key_table_unit.sv */
// Self-checking testbench for the sorted key table: directed corner cases, then random traffic.
`timescale 1ns / 1ps

module tb_sorted_key_table_unit;
	import skt_pkg::*;

	localparam int TABLE_DEPTH = 8;
	localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;
	localparam int POOL_DEPTH = 24;

	typedef struct packed {
		status_t               status;
		logic [POS_OUT_W-1:0]  position;
		logic [CNT_OUT_W-1:0]  count;
	} table_response_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         req_valid = 1'b0;
	logic                         req_ready;
	logic [ACT_W-1:0]             action = ACT_INSERT;
	logic signed [KEY_W-1:0]      key = '0;
	logic                         rsp_valid;
	logic                         rsp_ready = 1'b0;
	logic [STS_W-1:0]             status;
	logic [POS_OUT_W-1:0]         position;
	logic [CNT_OUT_W-1:0]         count;

	// Shadow copy of the table, advanced on every accepted request
	logic signed [KEY_W-1:0]      table_keys [TABLE_DEPTH];
	int unsigned                  stored_count = 0;
	table_response_t              expected_responses [$];

	// Stimulus side: keys recently inserted, to hit present entries
	logic signed [KEY_W-1:0]      key_pool [$];
	bit                           idling_on = 1'b1;
	int                           stall_left = 0;
	int                           fail_count = 0;
	int                           actions_seen [4] = '{default: 0};
	int                           statuses_seen [4] = '{default: 0};

	sorted_key_table_unit #(.CAPACITY(TABLE_DEPTH)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.action    (action),
		.key       (key),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.status    (status),
		.position  (position),
		.count     (count)
	);

	always #5 clk = ~clk;

	// Table behaviour: work out the response and update the shadow copy
	function automatic table_response_t apply_request(input action_t act,
			input logic signed [KEY_W-1:0] k);
		table_response_t rsp;
		int unsigned i;
		bit found;
		rsp.status = STS_OK;
		rsp.position = '0;
		found = 1'b0;
		case (act)
			ACT_INSERT: begin
				if (stored_count >= TABLE_DEPTH) begin
					rsp.status = STS_FULL;
				end else begin
					i = 0;
					while (i < stored_count && table_keys[i] < k)
						i++;
					if (i < stored_count && table_keys[i] == k) begin
						rsp.status = STS_DUP;
					end else begin
						for (int j = stored_count; j > i; j--)
							table_keys[j] = table_keys[j-1];
						table_keys[i] = k;
						stored_count++;
						rsp.position = i[POS_OUT_W-1:0];
					end
				end
			end
			ACT_DELETE, ACT_SEARCH: begin
				for (i = 0; i < stored_count && !found; i++) begin
					if (table_keys[i] == k) begin
						found = 1'b1;
						rsp.position = i[POS_OUT_W-1:0];
					end
				end
				if (!found) begin
					rsp.status = STS_MISSING;
					rsp.position = '0;
				end else if (act == ACT_DELETE) begin
					for (int j = rsp.position; j + 1 < stored_count; j++)
						table_keys[j] = table_keys[j+1];
					stored_count--;
				end
			end
			default: stored_count = 0;
		endcase
		rsp.count = stored_count[CNT_OUT_W-1:0];
		return rsp;
	endfunction

	// Predict on each accepted request, check each accepted response
	always @(posedge clk) begin : response_checker
		table_response_t want;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				actions_seen[action]++;
				expected_responses.push_back(apply_request(action_t'(action), key));
			end
			if (rsp_valid && rsp_ready) begin
				if (expected_responses.size() == 0) begin
					$error("response with no request outstanding");
					fail_count++;
				end else begin
					want = expected_responses.pop_front();
					statuses_seen[status]++;
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						fail_count++;
					end
					if (position !== want.position) begin
						$error("position: expected %0d, got %0d", want.position, position);
						fail_count++;
					end
					if (count !== want.count) begin
						$error("count: expected %0d, got %0d", want.count, count);
						fail_count++;
					end
				end
			end
		end
	end

	// Response back-pressure in random bursts while idling is on, else always ready
	always @(posedge clk) begin
		if (!idling_on) begin
			rsp_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_ready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 5) - 1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	// Present one request, after a random idle gap while idling is on, and hold it until accepted
	task automatic send_request(input action_t act, input logic signed [KEY_W-1:0] k);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		req_valid <= 1'b1;
		action <= act;
		key <= k;
		do @(posedge clk); while (!req_ready);
		if (act == ACT_INSERT) begin
			key_pool.push_back(k);
			if (key_pool.size() > POOL_DEPTH)
				void'(key_pool.pop_front());
		end
	endtask

	function automatic logic signed [KEY_W-1:0] pick_key(input bit narrow);
		logic signed [KEY_W-1:0] k;
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel < 5 && key_pool.size() != 0)
			k = key_pool[$urandom_range(0, key_pool.size() - 1)];
		else if (sel < 7 || narrow)
			k = $signed($urandom_range(0, 40)) - 20;
		else if (sel == 7)
			case ($urandom_range(0, 5))
				0: k = KEY_MIN;
				1: k = KEY_MIN + 1;
				2: k = KEY_MAX;
				3: k = KEY_MAX - 1;
				4: k = -1;
				default: k = 0;
			endcase
		else
			k = $urandom;
		return k;
	endfunction

	function automatic action_t pick_action(input int ins_pct, input int del_pct,
			input int srch_pct);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < ins_pct)
			return ACT_INSERT;
		if (r < ins_pct + del_pct)
			return ACT_DELETE;
		if (r < ins_pct + del_pct + srch_pct)
			return ACT_SEARCH;
		return ACT_CLEAR;
	endfunction

	// Ordering extremes, full table, duplicates, misses and stale cells after clear
	task automatic test_directed_edges();
		send_request(ACT_SEARCH, 5);
		send_request(ACT_DELETE, 5);
		send_request(ACT_INSERT, KEY_MAX);
		send_request(ACT_INSERT, KEY_MIN);
		send_request(ACT_INSERT, 0);
		send_request(ACT_INSERT, -1);
		send_request(ACT_INSERT, 1);
		send_request(ACT_INSERT, 0);
		send_request(ACT_SEARCH, KEY_MIN);
		send_request(ACT_SEARCH, KEY_MAX);
		send_request(ACT_INSERT, -100);
		send_request(ACT_INSERT, 100);
		send_request(ACT_INSERT, KEY_MAX - 1);
		// table is now full: a new key and a duplicate both report full
		send_request(ACT_INSERT, 7);
		send_request(ACT_INSERT, 0);
		send_request(ACT_SEARCH, 7);
		send_request(ACT_DELETE, -1);
		send_request(ACT_DELETE, KEY_MIN);
		send_request(ACT_DELETE, KEY_MAX);
		send_request(ACT_SEARCH, KEY_MAX);
		send_request(ACT_CLEAR, KEY_MAX);
		// cells above the count still hold old keys and must not match
		send_request(ACT_SEARCH, 0);
		send_request(ACT_DELETE, 100);
		send_request(ACT_INSERT, 100);
		send_request(ACT_CLEAR, -1);
	endtask

	// Mixed traffic over the full key range with idling on both sides
	task automatic test_random_mixed(input int n_items);
		action_t act;
		repeat (n_items) begin
			act = pick_action(45, 25, 26);
			send_request(act, pick_key(1'b0));
		end
	endtask

	// Insert-heavy traffic on a narrow key range: table keeps filling and emptying
	task automatic test_full_table_churn(input int n_items);
		action_t act;
		repeat (n_items) begin
			act = pick_action(60, 25, 13);
			send_request(act, pick_key(1'b1));
		end
	endtask

	// Requests at full rate with no back-pressure, with some noise
	task automatic test_back_to_back(input int n_items);
		action_t act;
		repeat (n_items) begin
			if ($urandom_range(0, 9) == 0) begin
				act = action_t'($urandom_range(0, 3));
				send_request(act, $urandom);
			end else begin
				act = pick_action(45, 25, 27);
				send_request(act, pick_key(1'b0));
			end
		end
	endtask

	initial begin : run
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_edges();
		test_random_mixed(180);
		test_full_table_churn(120);
		idling_on = 1'b0;
		test_back_to_back(100);
		req_valid <= 1'b0;
		while (expected_responses.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		$display("Requests insert/delete/search/clear: %0d/%0d/%0d/%0d",
			actions_seen[ACT_INSERT], actions_seen[ACT_DELETE],
			actions_seen[ACT_SEARCH], actions_seen[ACT_CLEAR]);
		$display("Responses ok/full/duplicate/missing: %0d/%0d/%0d/%0d, mismatches: %0d",
			statuses_seen[STS_OK], statuses_seen[STS_FULL],
			statuses_seen[STS_DUP], statuses_seen[STS_MISSING], fail_count);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Watchdog
	initial begin
		#1_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
